>>> src/alt_pkg.sv
// Shared types, character codes and operator lookups for the assembler line tokenizer.
// No dependencies.
package alt_pkg;

	typedef enum logic [2:0] {
		CLS_SPACE   = 3'd0,
		CLS_TAB     = 3'd1,
		CLS_COMMENT = 3'd2,
		CLS_PAIR    = 3'd3,
		CLS_SINGLE  = 3'd4,
		CLS_WORD    = 3'd5,
		CLS_NONE    = 3'd7
	} class_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;

	// one result beat
	typedef struct packed {
		logic       last;
		class_t     token_class;
		logic       token_start;
		logic [7:0] out_char;
	} result_t;

	// lexer status for checks
	typedef struct packed {
		logic held_valid;
		logic pair_wait;
	} lex_status_t;

	// one-character operators: []()<>=&|$%*/#+@-~;:!,
	function automatic logic is_single(input logic [7:0] c);
		logic r;
		case (c)
			8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3C, 8'h3E, 8'h3D, 8'h26,
			8'h7C, 8'h24, 8'h25, 8'h2A, 8'h2F, 8'h23, 8'h2B, 8'h40,
			8'h2D, 8'h7E, 8'h3B, 8'h3A, 8'h21, 8'h2C: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// first byte of some two-character operator
	function automatic logic may_begin_pair(input logic [7:0] c);
		return (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) || (c == CH_BANG) ||
			(c == CH_AMP) || (c == CH_BAR);
	endfunction

	// << >> <= >= == != && ||
	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return ((a == CH_LT) && ((b == CH_LT) || (b == CH_EQ))) ||
			((a == CH_GT) && ((b == CH_GT) || (b == CH_EQ))) ||
			((a == CH_EQ) && (b == CH_EQ)) ||
			((a == CH_BANG) && (b == CH_EQ)) ||
			((a == CH_AMP) && (b == CH_AMP)) ||
			((a == CH_BAR) && (b == CH_BAR));
	endfunction

endpackage

>>> src/alt_lexer.sv
// Token state and classification: one byte of lookahead, up to two results per byte.
// Depends on alt_pkg.
module alt_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,       // consume the byte below
	input  logic [7:0]           char_in,
	input  logic                 end_in,
	output alt_pkg::result_t     res_held,   // delayed result of the held byte
	output logic                 res_held_valid,
	output alt_pkg::result_t     res_cur,    // own result of a line-end byte
	output logic                 res_cur_valid,
	output alt_pkg::lex_status_t status
);

	logic [7:0]      held_char_q;
	logic            held_valid_q;
	alt_pkg::class_t held_class_q;
	logic            held_start_q;
	alt_pkg::class_t run_class_q;
	logic            in_quotes_q;
	logic            after_bs_q;

	alt_pkg::class_t hcls, cls, run_n;
	logic            start, done, quotes_n, bs_n;
	logic            word_go;

	always_comb begin
		hcls     = held_class_q;
		run_n    = run_class_q;
		cls      = alt_pkg::CLS_WORD;
		start    = 1'b1;
		done     = 1'b0;
		quotes_n = in_quotes_q;
		bs_n     = after_bs_q;
		word_go  = after_bs_q || in_quotes_q ||
			(!alt_pkg::is_single(char_in) && char_in != alt_pkg::CH_SPACE &&
			char_in != alt_pkg::CH_TAB);

		// resolve a pending operator pair
		if (held_valid_q && run_class_q == alt_pkg::CLS_PAIR) begin
			if (alt_pkg::is_pair(held_char_q, char_in)) begin
				hcls  = alt_pkg::CLS_PAIR;
				cls   = alt_pkg::CLS_PAIR;
				start = 1'b0;
				done  = 1'b1;
			end else begin
				hcls = alt_pkg::CLS_SINGLE;
			end
			run_n = alt_pkg::CLS_NONE;
		end

		if (!done) begin
			if (run_n == alt_pkg::CLS_SPACE && char_in == alt_pkg::CH_SPACE) begin
				cls   = alt_pkg::CLS_SPACE;
				start = 1'b0;
			end else if (run_n == alt_pkg::CLS_TAB && char_in == alt_pkg::CH_TAB) begin
				cls   = alt_pkg::CLS_TAB;
				start = 1'b0;
			end else if (run_n == alt_pkg::CLS_COMMENT) begin
				cls   = alt_pkg::CLS_COMMENT;
				start = 1'b0;
			end else if (run_n == alt_pkg::CLS_WORD && word_go) begin
				cls   = alt_pkg::CLS_WORD;
				start = 1'b0;
				bs_n  = !after_bs_q && char_in == alt_pkg::CH_BSLASH;
				if (!bs_n && char_in == alt_pkg::CH_QUOTE)
					quotes_n = !in_quotes_q;
			end else begin
				start    = 1'b1;
				quotes_n = 1'b0;
				bs_n     = 1'b0;
				if (char_in == alt_pkg::CH_SPACE) begin
					cls   = alt_pkg::CLS_SPACE;
					run_n = alt_pkg::CLS_SPACE;
				end else if (char_in == alt_pkg::CH_TAB) begin
					cls   = alt_pkg::CLS_TAB;
					run_n = alt_pkg::CLS_TAB;
				end else if (char_in == alt_pkg::CH_SEMI) begin
					cls   = alt_pkg::CLS_COMMENT;
					run_n = alt_pkg::CLS_COMMENT;
				end else if (alt_pkg::may_begin_pair(char_in)) begin
					cls   = alt_pkg::CLS_SINGLE;
					run_n = alt_pkg::CLS_PAIR;
				end else if (alt_pkg::is_single(char_in)) begin
					cls   = alt_pkg::CLS_SINGLE;
					run_n = alt_pkg::CLS_NONE;
				end else begin
					cls      = alt_pkg::CLS_WORD;
					run_n    = alt_pkg::CLS_WORD;
					bs_n     = char_in == alt_pkg::CH_BSLASH;
					quotes_n = !bs_n && char_in == alt_pkg::CH_QUOTE;
				end
			end
		end
	end

	always_comb begin
		res_held.out_char    = (hcls == alt_pkg::CLS_TAB && held_char_q == alt_pkg::CH_TAB) ?
			alt_pkg::CH_SPACE : held_char_q;
		res_held.token_start = held_start_q;
		res_held.token_class = hcls;
		res_held.last        = 1'b0;
		res_held_valid       = held_valid_q;

		res_cur.out_char     = (cls == alt_pkg::CLS_TAB && char_in == alt_pkg::CH_TAB) ?
			alt_pkg::CH_SPACE : char_in;
		res_cur.token_start  = start;
		res_cur.token_class  = cls;
		res_cur.last         = 1'b1;
		res_cur_valid        = end_in;

		status.held_valid    = held_valid_q;
		status.pair_wait     = run_class_q == alt_pkg::CLS_PAIR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			held_class_q <= alt_pkg::CLS_SPACE;
			held_start_q <= 1'b0;
			run_class_q  <= alt_pkg::CLS_NONE;
			in_quotes_q  <= 1'b0;
			after_bs_q   <= 1'b0;
		end else if (step) begin
			if (end_in) begin
				held_char_q  <= '0;
				held_valid_q <= 1'b0;
				held_class_q <= alt_pkg::CLS_SPACE;
				held_start_q <= 1'b0;
				run_class_q  <= alt_pkg::CLS_NONE;
				in_quotes_q  <= 1'b0;
				after_bs_q   <= 1'b0;
			end else begin
				held_char_q  <= char_in;
				held_valid_q <= 1'b1;
				held_class_q <= cls;
				held_start_q <= start;
				run_class_q  <= run_n;
				in_quotes_q  <= quotes_n;
				after_bs_q   <= bs_n;
			end
		end
	end

endmodule

>>> src/alt_out_fifo.sv
// Two-entry result queue, takes up to two results in one cycle, gives one per cycle while q_ready is high.
// Depends on alt_pkg.
module alt_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  alt_pkg::result_t d_a,      // first in order
	input  logic             d_a_valid,
	input  alt_pkg::result_t d_b,      // second in order
	input  logic             d_b_valid,
	output alt_pkg::result_t q,
	output logic             q_valid,
	input  logic             q_ready,
	output logic [1:0]       count
);

	alt_pkg::result_t mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             pop;
	logic [1:0]       n_push;
	alt_pkg::result_t first;

	assign pop    = q_valid && q_ready;
	assign n_push = {1'b0, d_a_valid} + {1'b0, d_b_valid};
	assign first  = d_a_valid ? d_a : d_b;
	assign q      = mem_q[rd_q];
	assign q_valid = cnt_q != 2'd0;
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_q] <= first;
		if (n_push == 2'd2)
			mem_q[~wr_q] <= d_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			wr_q  <= wr_q ^ n_push[0];
			rd_q  <= rd_q ^ pop;
			cnt_q <= cnt_q + n_push - {1'b0, pop};
		end
	end

endmodule

>>> src/assembler_line_tokenizer.sv
// Assembler line tokenizer. Bytes of a source line arrive one per beat on the s_ side
// (s_tlast on the final byte) and leave on the m_ side with a token-start flag and a
// token class: space run, tab run (tabs shown as spaces), comment, two-character
// operator, one-character operator or word. Each byte's result is held back until the next
// byte arrives, since the operator pair check needs it; the line-end beat releases both the
// held result, if any, and its own, the latter with m_tlast. Sustained rate is one byte per
// cycle while m_tready stays high; a line-end byte that flushes two results waits until the
// single-result output port has drained the two-entry result queue. A line-end byte has
// its first result offered after the input register and then a write into the result queue,
// once the queue has room; any other byte waits in addition until the next byte is processed,
// for the one-byte lookahead. s_tready does not depend on m_tready.
// Depends on alt_pkg, alt_lexer, alt_out_fifo.
module assembler_line_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] character
	input  logic       s_tlast,    // line end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_char
	output logic [3:0] m_tuser,    // [0] token_start, [3:1] token_class
	output logic       m_tlast     // last result of the line
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	alt_pkg::result_t     res_held, res_cur, res_out;
	logic                 res_held_valid, res_cur_valid;
	alt_pkg::lex_status_t lex_status;
	logic [1:0]           fifo_count;
	logic [1:0]           need, free;
	logic                 proc_fire;

	// a byte moves on only when the queue has room for every result it releases
	assign need      = {1'b0, lex_status.held_valid} + {1'b0, end_s1};
	assign free      = 2'd2 - fifo_count;
	assign proc_fire = valid_s1 && (need <= free);
	assign s_tready  = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	alt_lexer u_lexer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (proc_fire),
		.char_in        (char_s1),
		.end_in         (end_s1),
		.res_held       (res_held),
		.res_held_valid (res_held_valid),
		.res_cur        (res_cur),
		.res_cur_valid  (res_cur_valid),
		.status         (lex_status)
	);

	alt_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.d_a       (res_held),
		.d_a_valid (proc_fire && res_held_valid),
		.d_b       (res_cur),
		.d_b_valid (proc_fire && res_cur_valid),
		.q         (res_out),
		.q_valid   (m_tvalid),
		.q_ready   (m_tready),
		.count     (fifo_count)
	);

	assign m_tdata = res_out.out_char;
	assign m_tuser = {res_out.token_class, res_out.token_start};
	assign m_tlast = res_out.last;

`ifndef SYNTHESIS
	// queue never holds more than two results
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count != 2'd3)
		else $error("result queue overflow");

	// a line-end byte leaves the lexer with nothing held
	a_line_flush: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && end_s1 |=> !lex_status.held_valid)
		else $error("byte still held after line end");

	// a pending pair always has its first byte held
	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		lex_status.pair_wait |-> lex_status.held_valid)
		else $error("pair wait without held byte");
`endif

endmodule

>>> tb/tb_assembler_line_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for assembler_line_tokenizer: directed and random source lines in,
// predicted token marks compared beat by beat against the m_ stream.
// Depends on alt_pkg and the tokenizer RTL.
module tb_assembler_line_tokenizer;

	localparam int HOLD_CYCLES = 300;
	localparam int N_SINGLE    = 22;
	localparam int N_PAIR      = 8;
	localparam logic [8*N_SINGLE-1:0] SINGLE_OPS = "[]()<>=&|$%*/#+@-~;:!,";
	localparam logic [16*N_PAIR-1:0]  PAIR_OPS   = "<<>><=>===!=&&||";

	// one source byte waiting to be driven
	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} src_beat_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [3:0] m_tuser;
	logic       m_tlast;

	assembler_line_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run-wide knobs, written by the stimulus process at falling edges only
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	logic hold_req     = 1'b0;  // toggled to ask the receiver for a long hold-off

	src_beat_t        line_q[$];    // bytes still to be offered
	alt_pkg::result_t token_q[$];   // token marks predicted but not yet seen
	src_beat_t        nxt_beat;
	alt_pkg::result_t got_beat;
	alt_pkg::result_t want_beat;
	logic             hold_seen = 1'b0;
	int               hold_left = 0;

	int n_queued  = 0;
	int n_bytes   = 0;
	int n_lines   = 0;
	int n_results = 0;
	int n_faults  = 0;

	// ---------------------------------------------------------------------------------
	// Token predictor: own copy of the lexer state, stepped on every accepted byte
	// ---------------------------------------------------------------------------------
	logic [7:0]      lx_held_char  = 8'h00;
	logic            lx_held_valid = 1'b0;
	alt_pkg::class_t lx_held_cls   = alt_pkg::CLS_SPACE;
	logic            lx_held_start = 1'b0;
	alt_pkg::class_t lx_run        = alt_pkg::CLS_NONE;   // CLS_PAIR while a held byte waits
	logic            lx_quoted     = 1'b0;
	logic            lx_escaped    = 1'b0;

	function automatic logic [7:0] single_byte(input int i);
		return SINGLE_OPS[8*i +: 8];
	endfunction

	// k = 0 first byte of pair p, k = 1 second byte
	function automatic logic [7:0] pair_byte(input int p, input int k);
		return PAIR_OPS[8*(2*N_PAIR-1-2*p-k) +: 8];
	endfunction

	function automatic logic op_byte(input logic [7:0] c);
		logic hit;
		int i;
		hit = 1'b0;
		for (i = 0; i < N_SINGLE; i++)
			if (single_byte(i) == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic pair_opener(input logic [7:0] c);
		logic hit;
		int p;
		hit = 1'b0;
		for (p = 0; p < N_PAIR; p++)
			if (pair_byte(p, 0) == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic pair_match(input logic [7:0] a, input logic [7:0] b);
		logic hit;
		int p;
		hit = 1'b0;
		for (p = 0; p < N_PAIR; p++)
			if (pair_byte(p, 0) == a && pair_byte(p, 1) == b)
				hit = 1'b1;
		return hit;
	endfunction

	// tabs leave as spaces only inside a tab run
	function automatic alt_pkg::result_t token_mark(input logic [7:0] c,
			input alt_pkg::class_t cls, input logic st, input logic lst);
		alt_pkg::result_t r;
		r.out_char    = (cls == alt_pkg::CLS_TAB && c == alt_pkg::CH_TAB) ?
			alt_pkg::CH_SPACE : c;
		r.token_start = st;
		r.token_class = cls;
		r.last        = lst;
		return r;
	endfunction

	// quote and backslash tracking inside a word
	task automatic word_step(input logic [7:0] c);
		lx_escaped = !lx_escaped && (c == alt_pkg::CH_BSLASH);
		if (!lx_escaped && c == alt_pkg::CH_QUOTE)
			lx_quoted = !lx_quoted;
	endtask

	task automatic tokenize_byte(input logic [7:0] c, input logic eol);
		alt_pkg::class_t cls;
		logic            st;
		logic            paired;
		cls    = alt_pkg::CLS_WORD;
		st     = 1'b1;
		paired = 1'b0;

		// settle the held operator now that its successor is known
		if (lx_held_valid && lx_run == alt_pkg::CLS_PAIR) begin
			if (pair_match(lx_held_char, c)) begin
				lx_held_cls = alt_pkg::CLS_PAIR;
				cls         = alt_pkg::CLS_PAIR;
				st          = 1'b0;
				paired      = 1'b1;
			end else begin
				lx_held_cls = alt_pkg::CLS_SINGLE;
			end
			lx_run = alt_pkg::CLS_NONE;
		end

		if (!paired) begin
			if (lx_run == alt_pkg::CLS_SPACE && c == alt_pkg::CH_SPACE) begin
				cls = alt_pkg::CLS_SPACE;
				st  = 1'b0;
			end else if (lx_run == alt_pkg::CLS_TAB && c == alt_pkg::CH_TAB) begin
				cls = alt_pkg::CLS_TAB;
				st  = 1'b0;
			end else if (lx_run == alt_pkg::CLS_COMMENT) begin
				cls = alt_pkg::CLS_COMMENT;
				st  = 1'b0;
			end else if (lx_run == alt_pkg::CLS_WORD && (lx_escaped || lx_quoted ||
					(!op_byte(c) && c != alt_pkg::CH_SPACE && c != alt_pkg::CH_TAB))) begin
				cls = alt_pkg::CLS_WORD;
				st  = 1'b0;
				word_step(c);
			end else begin
				st         = 1'b1;
				lx_quoted  = 1'b0;
				lx_escaped = 1'b0;
				if (c == alt_pkg::CH_SPACE) begin
					cls    = alt_pkg::CLS_SPACE;
					lx_run = alt_pkg::CLS_SPACE;
				end else if (c == alt_pkg::CH_TAB) begin
					cls    = alt_pkg::CLS_TAB;
					lx_run = alt_pkg::CLS_TAB;
				end else if (c == alt_pkg::CH_SEMI) begin
					cls    = alt_pkg::CLS_COMMENT;
					lx_run = alt_pkg::CLS_COMMENT;
				end else if (pair_opener(c)) begin
					cls    = alt_pkg::CLS_SINGLE;  // provisional until the next byte
					lx_run = alt_pkg::CLS_PAIR;
				end else if (op_byte(c)) begin
					cls    = alt_pkg::CLS_SINGLE;
					lx_run = alt_pkg::CLS_NONE;
				end else begin
					cls    = alt_pkg::CLS_WORD;
					lx_run = alt_pkg::CLS_WORD;
					word_step(c);
				end
			end
		end

		if (lx_held_valid)
			token_q = {token_q, token_mark(lx_held_char, lx_held_cls, lx_held_start, 1'b0)};

		if (eol) begin
			// line end flushes this byte too; a pending pair opener stays single
			token_q = {token_q, token_mark(c, cls, st, 1'b1)};
			lx_held_char  = 8'h00;
			lx_held_valid = 1'b0;
			lx_held_cls   = alt_pkg::CLS_SPACE;
			lx_held_start = 1'b0;
			lx_run        = alt_pkg::CLS_NONE;
			lx_quoted     = 1'b0;
			lx_escaped    = 1'b0;
		end else begin
			lx_held_char  = c;
			lx_held_cls   = cls;
			lx_held_start = st;
			lx_held_valid = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Driver: offers queued bytes, predicts on every accepted beat
	// ---------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				tokenize_byte(s_tdata, s_tlast);
				n_bytes++;
				if (s_tlast)
					n_lines++;
			end
			// slot is free once the current beat has gone (or none was offered)
			if (!s_tvalid || s_tready) begin
				if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt_beat = line_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt_beat.ch;
					s_tlast  <= nxt_beat.eol;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Monitor and receiver: checks each result beat, drives m_tready with random
	// stalls and the requested long hold-off
	// ---------------------------------------------------------------------------------
	task automatic note_fault(input string what, input alt_pkg::result_t want,
			input alt_pkg::result_t got);
		n_faults++;
		if (n_faults <= 10)
			$display("%0t %s: want char %02h start %0d class %0d last %0d, %s",
				$time, what, want.out_char, want.token_start, want.token_class, want.last,
				$sformatf("got char %02h start %0d class %0d last %0d",
				got.out_char, got.token_start, got.token_class, got.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got_beat.out_char    = m_tdata;
				got_beat.token_start = m_tuser[0];
				got_beat.token_class = alt_pkg::class_t'(m_tuser[3:1]);
				got_beat.last        = m_tlast;
				if (token_q.size() == 0) begin
					note_fault("unexpected beat", '0, got_beat);
				end else begin
					want_beat = token_q.pop_front();
					if (got_beat.out_char !== want_beat.out_char ||
							got_beat.token_start !== want_beat.token_start ||
							got_beat.token_class !== want_beat.token_class ||
							got_beat.last !== want_beat.last)
						note_fault("wrong beat", want_beat, got_beat);
				end
			end

			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] c, input logic eol);
		src_beat_t b;
		b.ch  = c;
		b.eol = eol;
		line_q = {line_q, b};
		n_queued++;
	endtask

	task automatic queue_text(input string txt);
		int i;
		for (i = 0; i < txt.len(); i++)
			queue_byte(txt[i], i == txt.len() - 1);
	endtask

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		return b;
	endfunction

	// mostly lower-case letters, now and then any byte at all
	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		if ($urandom_range(0, 9) == 0)
			b = any_byte();
		else
			b = 8'h61 + 8'($urandom_range(0, 25));
		return b;
	endfunction

	// a line built from plausible tokens with random content, plus some noise
	task automatic queue_random_line();
		logic [7:0] txt[$];
		int n_tok;
		int k;
		int j;
		int len;
		n_tok = $urandom_range(1, 8);
		for (k = 0; k < n_tok; k++) begin
			case ($urandom_range(0, 11))
				0: begin
					len = $urandom_range(1, 3);
					repeat (len) txt = {txt, alt_pkg::CH_SPACE};
				end
				1: begin
					len = $urandom_range(1, 3);
					repeat (len) txt = {txt, alt_pkg::CH_TAB};
				end
				2, 3, 4: begin
					len = $urandom_range(1, 6);
					repeat (len) txt = {txt, word_byte()};
				end
				5: txt = {txt, single_byte($urandom_range(0, N_SINGLE - 1))};
				6: begin
					j = $urandom_range(0, N_PAIR - 1);
					txt = {txt, pair_byte(j, 0), pair_byte(j, 1)};
				end
				7: begin
					// comment swallows the rest of the line, tabs included
					txt = {txt, alt_pkg::CH_SEMI};
					len = $urandom_range(0, 6);
					repeat (len)
						txt = {txt, ($urandom_range(0, 3) == 0) ? alt_pkg::CH_TAB : any_byte()};
				end
				8: txt = {txt, any_byte()};
				9: begin
					// quoted string with blanks and operators inside
					txt = {txt, alt_pkg::CH_QUOTE};
					len = $urandom_range(0, 5);
					repeat (len) begin
						case ($urandom_range(0, 3))
							0: txt = {txt, alt_pkg::CH_SPACE};
							1: txt = {txt, alt_pkg::CH_TAB};
							2: txt = {txt, single_byte($urandom_range(0, N_SINGLE - 1))};
							default: txt = {txt, any_byte()};
						endcase
					end
					txt = {txt, alt_pkg::CH_QUOTE};
				end
				10: begin
					// escaped terminator inside a word
					txt = {txt, word_byte(), alt_pkg::CH_BSLASH};
					case ($urandom_range(0, 4))
						0: txt = {txt, alt_pkg::CH_SPACE};
						1: txt = {txt, alt_pkg::CH_TAB};
						2: txt = {txt, alt_pkg::CH_QUOTE};
						3: txt = {txt, alt_pkg::CH_BSLASH};
						default: txt = {txt, single_byte($urandom_range(0, N_SINGLE - 1))};
					endcase
				end
				default: begin
					// operands glued to an operator, e.g. a<=b
					j = $urandom_range(0, N_PAIR - 1);
					txt = {txt, word_byte(), pair_byte(j, 0)};
					if ($urandom_range(0, 1) == 0)
						txt = {txt, pair_byte(j, 1)};
					txt = {txt, word_byte()};
				end
			endcase
		end
		for (j = 0; j < txt.size(); j++)
			queue_byte(txt[j], j == txt.size() - 1);
	endtask

	// waits until every queued byte has been sent and every predicted beat has been seen
	task automatic wait_drained();
		@(negedge clk);
		while (line_q.size() != 0 || s_tvalid || token_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
			input logic long_hold);
		int goal;
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		goal = n_queued + n_items;
		while (n_queued < goal)
			queue_random_line();
		// output held off while the sender keeps streaming, so s_tready must drop
		if (long_hold)
			hold_req = !hold_req;
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines: word, space run, pair ==, tab run, '!' as the last byte
		queue_text("x  ==\t\t!");
		// quoted blank, escaped blank, then a comment keeping its tab
		queue_text("\"a b\"\\ ;\t");
		// one-byte lines at the ends of the byte range
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h01, 1'b1);
		// pair openers that do not pair up
		queue_text("<>&");
		wait_drained();

		run_phase(0, 0, 380, 1'b0);
		run_phase(83, 0, 380, 1'b0);
		run_phase(0, 83, 380, 1'b0);
		run_phase(19, 19, 200, 1'b0);
		run_phase(0, 0, 180, 1'b1);

		repeat (10) @(posedge clk);
		if (token_q.size() != 0) begin
			n_faults += token_q.size();
			$display("%0d predicted beats never arrived", token_q.size());
		end
		$display("Covered %0d bytes in %0d lines, %0d token beats checked", n_bytes, n_lines,
			n_results);
		$display("Phases: free flow, sparse input, sparse output, mixed, %0d-cycle output hold",
			HOLD_CYCLES);
		if (n_faults == 0)
			$display("assembler_line_tokenizer: match");
		else
			$display("assembler_line_tokenizer: mismatch");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#400000;
		$display("assembler_line_tokenizer: mismatch");
		$finish;
	end

endmodule
